### rtl/alb_pkg.sv
`timescale 1ns / 1ps

package alb_pkg;

  // register indexes on the configuration port
  localparam logic [3:0] REG_R0SQ  = 4'd0;
  localparam logic [3:0] REG_CONE  = 4'd1;
  localparam logic [3:0] REG_ECC   = 4'd2;
  localparam logic [3:0] REG_SOUTH = 4'd3;

  localparam logic [47:0] R0SQ_RST = 48'd4294967296;
  localparam logic [31:0] CONE_RST = 32'd1073741824;

  // Q30 series constants, rounded to nearest
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [29:0] C23_Q30 = 30'd715827883;
  localparam logic [29:0] C35_Q30 = 30'd644245094;
  localparam logic [29:0] C47_Q30 = 30'd613566757;
  localparam logic [29:0] C59_Q30 = 30'd596523236;
  localparam logic [51:0] T_MAX   = 52'hF_FFFF_FFFF_FFFF;

  // angle constants, Q32
  localparam logic signed [37:0] PI_Q32      = 38'sd13493037705;
  localparam logic signed [37:0] TWO_PI_Q32  = 38'sd26986075409;
  localparam logic signed [37:0] FOUR_PI_Q32 = 38'sd53972150818;
  localparam logic signed [37:0] HALF_PI_Q32 = 38'sd6746518852;
  localparam logic [63:0]        QTR_PI_Q32  = 64'd3373259426;
  localparam logic signed [35:0] GAIN_Q32    = 36'sd2608131496;

  // registers from input to the root and rotated vector
  localparam int RAD_LAT = 105;

  typedef struct packed {
    logic [47:0]        r0sq;
    logic signed [31:0] cone;
    logic [31:0]        ecc;
    logic               south;
  } cfg_t;

  // atan(2^-i) in Q32 from its power series in Q62
  function automatic logic [63:0] atan_q32(input int unsigned i);
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned k;
    logic        plus;
    acc  = 64'd0;
    plus = 1'b1;
    if (i == 0) return QTR_PI_Q32;
    for (k = 1; k * i <= 62; k += 2) begin
      term = (64'd1 << (62 - k * i)) / 64'(k);
      acc  = plus ? acc + term : acc - term;
      plus = !plus;
    end
    return (acc + (64'd1 << 29)) >> 30;
  endfunction

endpackage

### rtl/alb_if.sv
`timescale 1ns / 1ps

interface alb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sin_lat;
  logic signed [31:0] lon_rad;
  modport source (output valid, output sin_lat, output lon_rad, input ready);
  modport sink   (input valid, input sin_lat, input lon_rad, output ready);
endinterface

interface alb_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] x_out;
  logic signed [47:0] y_out;
  logic               valid_res;
  modport source (output valid, output x_out, output y_out, output valid_res, input ready);
  modport sink   (input valid, input x_out, input y_out, input valid_res, output ready);
endinterface

### rtl/alb_radius.sv
`timescale 1ns / 1ps

module alb_radius (
  input  logic               clk,
  input  logic               en,
  input  alb_pkg::cfg_t      cfg,
  input  logic signed [31:0] sin_lat,
  output logic [42:0]        root,
  output logic               valid_res
);

  logic [32:0] sabs;
  logic [30:0] sc;
  logic [61:0] sqp;
  assign sabs = sin_lat[31] ? (33'd0 - {1'b1, sin_lat}) : {1'b0, sin_lat};
  assign sc   = (sabs > 33'(alb_pkg::ONE_Q30)) ? alb_pkg::ONE_Q30 : sabs[30:0];
  assign sqp  = 62'(sc) * 62'(sc);

  logic [30:0] sc1_r, sc2_r, sc3_r, sc4_r, sc5_r, sc6_r;
  logic        sn1_r, sn2_r, sn3_r, sn4_r, sn5_r, sn6_r, sn7_r, sn8_r;
  logic [32:0] sq1_r;
  logic [31:0] s2_r, s3_r, s4_r, s5_r;
  logic [29:0] h3_r;
  logic [30:0] h4_r;
  logic [31:0] h5_r, h6_r;
  logic [32:0] m7_r, q8_r;

  logic [64:0] sp;
  logic [61:0] hp3;
  logic [30:0] a4;
  logic [62:0] hp4;
  logic [31:0] a5, a6;
  logic [63:0] hp5, hp6, mp;
  logic [32:0] ser, wgt;
  logic [65:0] qp;

  assign sp  = 65'(cfg.ecc) * 65'(sq1_r);
  assign hp3 = 62'(s2_r) * 62'(alb_pkg::C59_Q30);
  assign a4  = 31'(h3_r) + 31'(alb_pkg::C47_Q30);
  assign hp4 = 63'(s3_r) * 63'(a4);
  assign a5  = 32'(h4_r) + 32'(alb_pkg::C35_Q30);
  assign hp5 = 64'(s4_r) * 64'(a5);
  assign a6  = h5_r + 32'(alb_pkg::C23_Q30);
  assign hp6 = 64'(s5_r) * 64'(a6);
  assign ser = 33'(h6_r) + 33'(alb_pkg::ONE_Q30);
  assign mp  = 64'(sc6_r) * 64'(ser);
  assign wgt = 33'h1_0000_0000 - 33'(cfg.ecc);
  assign qp  = 66'(m7_r) * 66'(wgt);

  // series, numerator and (1 - e2) scaling
  always_ff @(posedge clk) begin
    if (en) begin
      sc1_r <= sc;     sn1_r <= sin_lat[31]; sq1_r <= sqp[60:28];
      sc2_r <= sc1_r;  sn2_r <= sn1_r;       s2_r  <= sp[63:32];
      sc3_r <= sc2_r;  sn3_r <= sn2_r;       s3_r  <= s2_r;  h3_r <= hp3[61:32];
      sc4_r <= sc3_r;  sn4_r <= sn3_r;       s4_r  <= s3_r;  h4_r <= hp4[62:32];
      sc5_r <= sc4_r;  sn5_r <= sn4_r;       s5_r  <= s4_r;  h5_r <= hp5[63:32];
      sc6_r <= sc5_r;  sn6_r <= sn5_r;       h6_r  <= hp6[63:32];
      sn7_r <= sn6_r;  m7_r  <= mp[62:30];
      sn8_r <= sn7_r;  q8_r  <= qp[64:32];
    end
  end

  // divider set-up: quotient q*2^33/|n| saturates once q >= |n|*2^19
  logic [31:0] dabs;
  logic        ovf;
  assign dabs = cfg.cone[31] ? (32'd0 - cfg.cone) : cfg.cone;
  assign ovf  = (dabs == 32'd0) ? (q8_r != 33'd0)
                                : ({18'd0, q8_r} >= {dabs, 19'd0});

  logic [31:0] dv_rem_r  [53];
  logic [51:0] dv_quo_r  [53];
  logic [18:0] dv_q_r    [53];
  logic [31:0] dv_d_r    [53];
  logic        dv_ovf_r  [53];
  logic        dv_tneg_r [53];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0]  <= 32'(q8_r[32:19]);
      dv_quo_r[0]  <= '0;
      dv_q_r[0]    <= q8_r[18:0];
      // zero n with zero q must give a zero quotient; any nonzero divisor does
      dv_d_r[0]    <= (dabs == 32'd0) ? 32'd1 : dabs;
      dv_ovf_r[0]  <= ovf;
      dv_tneg_r[0] <= sn8_r ^ cfg.cone[31];
    end
  end

  for (genvar j = 0; j < 52; j++) begin : g_div
    localparam int K = 51 - j;
    logic        dbit;
    logic [32:0] trial;
    logic        ge;
    if (K >= 33) begin : g_bit
      assign dbit = dv_q_r[j][K-33];
    end else begin : g_zero
      assign dbit = 1'b0;
    end
    assign trial = {dv_rem_r[j], dbit};
    assign ge    = trial >= {1'b0, dv_d_r[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[j+1]  <= ge ? 32'(trial - {1'b0, dv_d_r[j]}) : trial[31:0];
        dv_quo_r[j+1]  <= {dv_quo_r[j][50:0], ge};
        dv_q_r[j+1]    <= dv_q_r[j];
        dv_d_r[j+1]    <= dv_d_r[j];
        dv_ovf_r[j+1]  <= dv_ovf_r[j];
        dv_tneg_r[j+1] <= dv_tneg_r[j];
      end
    end
  end

  logic [51:0]        tq;
  logic signed [54:0] rad;
  assign tq  = dv_ovf_r[52] ? alb_pkg::T_MAX : dv_quo_r[52];
  assign rad = dv_tneg_r[52] ? ({7'd0, cfg.r0sq} + {3'd0, tq})
                             : ({7'd0, cfg.r0sq} - {3'd0, tq});

  // bit-serial floor root of rad * 2^32, one result bit per stage
  logic [53:0] sq_v_r    [44];
  logic [45:0] sq_rem_r  [44];
  logic [42:0] sq_root_r [44];
  logic        sq_ok_r   [44];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_v_r[0]    <= rad[54] ? 54'd0 : {1'b0, rad[52:0]};
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_ok_r[0]   <= !rad[54];
    end
  end

  for (genvar j = 0; j < 43; j++) begin : g_sqrt
    localparam int I = 42 - j;
    logic [1:0]  pair;
    logic [45:0] remsh, trial;
    logic        ge;
    if (I >= 16) begin : g_pair
      assign pair = sq_v_r[j][2*I-31:2*I-32];
    end else begin : g_nopair
      assign pair = 2'b00;
    end
    assign remsh = {sq_rem_r[j][43:0], pair};
    assign trial = {1'b0, sq_root_r[j], 2'b01};
    assign ge    = remsh >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[j+1]  <= ge ? remsh - trial : remsh;
        sq_root_r[j+1] <= {sq_root_r[j][41:0], ge};
        sq_v_r[j+1]    <= sq_v_r[j];
        sq_ok_r[j+1]   <= sq_ok_r[j];
      end
    end
  end

  assign root      = sq_root_r[43];
  assign valid_res = sq_ok_r[43];

endmodule

### rtl/alb_angle.sv
`timescale 1ns / 1ps

module alb_angle #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic               clk,
  input  logic               en,
  input  alb_pkg::cfg_t      cfg,
  input  logic signed [31:0] lon_rad,
  output logic signed [35:0] cos_c,
  output logic signed [35:0] sin_c
);

  localparam int PAD = alb_pkg::RAD_LAT - 7 - CORDIC_STAGES;

  logic signed [63:0] prod1_r;
  logic signed [37:0] a2_r, a3_r, a4_r, a5_r;
  logic signed [37:0] a2, a3, a4, a5;

  // t = n*lon >> 27, then reduced into [0, 2pi) and on into (-pi, pi]
  assign a2 = {prod1_r[63], prod1_r[63:27]} + alb_pkg::FOUR_PI_Q32;
  assign a3 = (a2_r >= alb_pkg::FOUR_PI_Q32) ? a2_r - alb_pkg::FOUR_PI_Q32 : a2_r;
  assign a4 = (a3_r >= alb_pkg::TWO_PI_Q32) ? a3_r - alb_pkg::TWO_PI_Q32 : a3_r;
  assign a5 = (a4_r > alb_pkg::PI_Q32) ? a4_r - alb_pkg::TWO_PI_Q32 : a4_r;

  logic signed [35:0] cx_r [CORDIC_STAGES+1];
  logic signed [35:0] cy_r [CORDIC_STAGES+1];
  logic signed [35:0] cz_r [CORDIC_STAGES+1];
  logic               fl_r [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r <= $signed(cfg.cone) * lon_rad;
      a2_r    <= a2;
      a3_r    <= a3;
      a4_r    <= a4;
      a5_r    <= a5;
      cx_r[0] <= alb_pkg::GAIN_Q32;
      cy_r[0] <= '0;
      // fold into [-pi/2, pi/2]; sine and cosine change sign
      if (a5_r > alb_pkg::HALF_PI_Q32) begin
        cz_r[0] <= 36'(a5_r - alb_pkg::PI_Q32);
        fl_r[0] <= 1'b1;
      end else if (a5_r < -alb_pkg::HALF_PI_Q32) begin
        cz_r[0] <= 36'(a5_r + alb_pkg::PI_Q32);
        fl_r[0] <= 1'b1;
      end else begin
        cz_r[0] <= 36'(a5_r);
        fl_r[0] <= 1'b0;
      end
    end
  end

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
    localparam logic signed [35:0] ATAN = 36'(alb_pkg::atan_q32(j));
    logic signed [35:0] dx, dy;
    assign dx = cy_r[j] >>> j;
    assign dy = cx_r[j] >>> j;
    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[j+1] <= fl_r[j];
        if (!cz_r[j][35]) begin
          cx_r[j+1] <= cx_r[j] - dx;
          cy_r[j+1] <= cy_r[j] + dy;
          cz_r[j+1] <= cz_r[j] - ATAN;
        end else begin
          cx_r[j+1] <= cx_r[j] + dx;
          cy_r[j+1] <= cy_r[j] - dy;
          cz_r[j+1] <= cz_r[j] + ATAN;
        end
      end
    end
  end

  // sign fix-up, then delay to line up with the root
  logic signed [35:0] pd_x_r [PAD+1];
  logic signed [35:0] pd_y_r [PAD+1];

  always_ff @(posedge clk) begin
    if (en) begin
      pd_x_r[0] <= fl_r[CORDIC_STAGES] ? -cx_r[CORDIC_STAGES] : cx_r[CORDIC_STAGES];
      pd_y_r[0] <= fl_r[CORDIC_STAGES] ? -cy_r[CORDIC_STAGES] : cy_r[CORDIC_STAGES];
      for (int k = 1; k <= PAD; k++) begin
        pd_x_r[k] <= pd_x_r[k-1];
        pd_y_r[k] <= pd_y_r[k-1];
      end
    end
  end

  assign cos_c = pd_x_r[PAD];
  assign sin_c = pd_y_r[PAD];

endmodule

### rtl/albers_forward_projection_top.sv
`timescale 1ns / 1ps

// Albers equal-area conic projection, forward direction.
// in_ch carries (sin_lat Q2.30, lon_rad Q3.29); out_ch returns (x_out, y_out
// in Q16.32, valid_res). valid_res is low when the radicand went negative, and
// x_out and y_out are then zero. One result per transaction, in order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 r0 squared,
// 1 cone constant, 2 squared eccentricity, 3 south-pole flag); other indexes
// are ignored. Write only while no transaction is in flight.
// Throughput: one transaction per cycle while out_ch is not stalled. Results
// reach out_ch.valid through the 52-stage divider and the 43-stage square
// root in series; the CORDIC runs alongside and is delay-matched.
// Reset: the pipeline empties and the registers take their defaults
// (r0 squared 1.0, n 1.0, e2 0, northern sign of y).
// A stalled out_ch freezes the whole pipeline; in_ch.ready drops until the
// waiting result is taken, and nothing is lost or repeated.
module albers_forward_projection_top #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  alb_in_if.sink      in_ch,
  alb_out_if.source   out_ch
);

  localparam int LAT = alb_pkg::RAD_LAT + 3;

  alb_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.r0sq  <= alb_pkg::R0SQ_RST;
      cfg_r.cone  <= alb_pkg::CONE_RST;
      cfg_r.ecc   <= '0;
      cfg_r.south <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        alb_pkg::REG_R0SQ:  cfg_r.r0sq  <= cfg_wdata;
        alb_pkg::REG_CONE:  cfg_r.cone  <= cfg_wdata[31:0];
        alb_pkg::REG_ECC:   cfg_r.ecc   <= cfg_wdata[31:0];
        alb_pkg::REG_SOUTH: cfg_r.south <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  logic [42:0]        root;
  logic               rok;
  logic signed [35:0] cx, cy;
  logic signed [31:0] lon_rad_in;

  assign lon_rad_in = in_ch.lon_rad;

  alb_radius u_rad (
    .clk       (clk),
    .en        (en),
    .cfg       (cfg_r),
    .sin_lat   (in_ch.sin_lat),
    .root      (root),
    .valid_res (rok)
  );

  alb_angle #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_ang (
    .clk     (clk),
    .en      (en),
    .cfg     (cfg_r),
    .lon_rad (lon_rad_in),
    .cos_c   (cx),
    .sin_c   (cy)
  );

  // r * |c| >> 32, split at bit 16 of r as the rounding requires
  logic [35:0] cxm, cym;
  assign cxm = cx[35] ? (36'd0 - 36'(cx)) : 36'(cx);
  assign cym = cy[35] ? (36'd0 - 36'(cy)) : 36'(cy);

  logic [62:0] yhi_r, xhi_r;
  logic [51:0] ylo_r, xlo_r;
  logic        yneg1_r, xneg1_r, ok1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      yhi_r   <= 63'(cxm) * 63'(root[42:16]);
      ylo_r   <= 52'(cxm) * 52'(root[15:0]);
      xhi_r   <= 63'(cym) * 63'(root[42:16]);
      xlo_r   <= 52'(cym) * 52'(root[15:0]);
      yneg1_r <= cx[35] ^ !cfg_r.south;
      xneg1_r <= !cy[35];
      ok1_r   <= rok;
    end
  end

  logic [63:0] ysum, xsum;
  assign ysum = 64'(yhi_r) + 64'(ylo_r[51:16]);
  assign xsum = 64'(xhi_r) + 64'(xlo_r[51:16]);

  logic [47:0] yp2_r, xp2_r;
  logic        yneg2_r, xneg2_r, ok2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      yp2_r   <= ysum[63:16];
      xp2_r   <= xsum[63:16];
      yneg2_r <= yneg1_r;
      xneg2_r <= xneg1_r;
      ok2_r   <= ok1_r;
    end
  end

  logic [47:0] x_out_r, y_out_r;
  logic        vres_r;

  always_ff @(posedge clk) begin
    if (en) begin
      y_out_r <= yneg2_r ? (48'd0 - yp2_r) : yp2_r;
      x_out_r <= xneg2_r ? (48'd0 - xp2_r) : xp2_r;
      vres_r  <= ok2_r;
    end
  end

  assign out_ch.valid     = vld_r[LAT-1];
  assign out_ch.x_out     = x_out_r;
  assign out_ch.y_out     = y_out_r;
  assign out_ch.valid_res = vres_r;

  a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.valid_res) |-> (out_ch.x_out == '0 && out_ch.y_out == '0))
    else $error("clamped result is not zero");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted transaction lost at pipeline entry");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while output stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result presented straight after reset");

endmodule

### test/albers_forward_projection_top_tb.sv
`timescale 1ns / 1ps

module albers_forward_projection_top_tb;

  localparam int          STAGES      = 32;
  localparam int          LATENCY     = 108;
  localparam int          IDLE_LIMIT  = 6000;
  localparam int          N_PHASES    = 10;
  localparam int          RAND_ITEMS  = 90;
  localparam logic [3:0]  REG_UNUSED  = 4'd12;
  localparam longint      SIN_ONE     = 64'sd1073741824;
  localparam longint      LON_MAX     = 64'sd1686629713;

  typedef struct {
    logic signed [31:0] sin_lat;
    logic signed [31:0] lon_rad;
  } geo_point_t;

  typedef struct {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic               ok;
  } plane_point_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_index;
  logic [47:0] cfg_wdata;

  alb_in_if  in_ch ();
  alb_out_if out_ch ();

  albers_forward_projection_top #(.CORDIC_STAGES(STAGES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // shadow copy of the projection registers
  logic [47:0]        r0sq_sh;
  logic signed [31:0] cone_sh;
  logic [31:0]        ecc_sh;
  logic               south_sh;

  geo_point_t   pending_points[$];
  plane_point_t expected_points[$];
  int  errors;
  int  n_sent;
  int  n_recv;
  int  n_clamped;
  int  idle_cycles;
  bit  hold_send;
  bit  in_taken;
  int  gap_cnt;
  int  burst_cnt;
  int  stall_cnt;
  int  calm_cnt;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint unsigned arctan_step(int unsigned i);
    longint unsigned acc;
    longint unsigned term;
    int unsigned     k;
    bit              plus;
    acc  = 0;
    plus = 1'b1;
    if (i == 0) return alb_pkg::QTR_PI_Q32;
    for (k = 1; k * i <= 62; k += 2) begin
      term = (64'd1 << (62 - k * i)) / longint'(k);
      acc  = plus ? acc + term : acc - term;
      plus = !plus;
    end
    return (acc + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned floor_root_q32(longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned pair;
    longint unsigned trial;
    int              b;
    rem  = 0;
    root = 0;
    for (int i = 42; i >= 0; i--) begin
      b    = 2 * i;
      pair = (b >= 32) ? ((v >> (b - 32)) & 64'd3) : 64'd0;
      rem  = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint scale_by_radius(longint unsigned r, longint c);
    longint unsigned mag;
    longint unsigned p;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    p   = (mag * (r >> 16) + ((mag * (r & 64'hFFFF)) >> 16)) >> 16;
    return (c < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic plane_point_t project_point(geo_point_t pt);
    plane_point_t    res;
    longint          sn;
    longint unsigned sc, sq, s, h, series, m, q, tq, q1, r1, d, root;
    longint          rad, ang, cx, cy, cz, dx, dy, xo, yo;
    bit              sneg, tneg, flip;
    sn   = longint'(pt.sin_lat);
    sneg = sn < 0;
    sc   = sneg ? longint'(-sn) : sn;
    if (sc > SIN_ONE) sc = SIN_ONE;
    if (ecc_sh == 0) begin
      series = alb_pkg::ONE_Q30;
    end else begin
      sq = (sc * sc) >> 28;
      s  = (longint'(ecc_sh) * sq) >> 32;
      h  = (s * alb_pkg::C59_Q30) >> 32;
      h  = (s * (h + alb_pkg::C47_Q30)) >> 32;
      h  = (s * (h + alb_pkg::C35_Q30)) >> 32;
      h  = (s * (h + alb_pkg::C23_Q30)) >> 32;
      series = alb_pkg::ONE_Q30 + h;
    end
    m = (sc * series) >> 30;
    q = (m * ((64'd1 << 32) - longint'(ecc_sh))) >> 32;
    d = (cone_sh < 0) ? -longint'(cone_sh) : longint'(cone_sh);
    if (d == 0) begin
      tq = (q != 0) ? alb_pkg::T_MAX : 0;
    end else begin
      q1 = q / d;
      r1 = q % d;
      tq = (q1 >= (64'd1 << 19)) ? alb_pkg::T_MAX : (q1 << 33) + (r1 << 33) / d;
      if (tq > alb_pkg::T_MAX) tq = alb_pkg::T_MAX;
    end
    tneg = sneg != (cone_sh < 0);
    rad  = tneg ? longint'(r0sq_sh) + longint'(tq) : longint'(r0sq_sh) - longint'(tq);
    res.ok = rad >= 0;
    root   = res.ok ? floor_root_q32(rad) : 0;

    ang = (longint'(cone_sh) * longint'(pt.lon_rad)) >>> 27;
    ang = ang % longint'(alb_pkg::TWO_PI_Q32);
    if (ang < 0) ang += longint'(alb_pkg::TWO_PI_Q32);
    if (ang > longint'(alb_pkg::PI_Q32)) ang -= longint'(alb_pkg::TWO_PI_Q32);
    flip = 1'b0;
    if (ang > longint'(alb_pkg::HALF_PI_Q32)) begin
      ang -= longint'(alb_pkg::PI_Q32);
      flip = 1'b1;
    end else if (ang < -longint'(alb_pkg::HALF_PI_Q32)) begin
      ang += longint'(alb_pkg::PI_Q32);
      flip = 1'b1;
    end
    cx = longint'(alb_pkg::GAIN_Q32);
    cy = 0;
    cz = ang;
    for (int i = 0; i < STAGES && i < 63; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx -= dx;
        cy += dy;
        cz -= longint'(arctan_step(i));
      end else begin
        cx += dx;
        cy -= dy;
        cz += longint'(arctan_step(i));
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    yo = scale_by_radius(root, cx);
    if (!south_sh) yo = -yo;
    xo = -scale_by_radius(root, cy);
    res.x = xo[47:0];
    res.y = yo[47:0];
    return res;
  endfunction

  task automatic write_reg(input logic [3:0] idx, input logic [47:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      alb_pkg::REG_R0SQ:  r0sq_sh  = val;
      alb_pkg::REG_CONE:  cone_sh  = val[31:0];
      alb_pkg::REG_ECC:   ecc_sh   = val[31:0];
      alb_pkg::REG_SOUTH: south_sh = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_projection(input logic [47:0] r0, input logic [31:0] n,
                                input logic [31:0] e2, input logic sp);
    write_reg(alb_pkg::REG_R0SQ, r0);
    write_reg(alb_pkg::REG_CONE, {16'd0, n});
    write_reg(alb_pkg::REG_ECC, {16'd0, e2});
    write_reg(alb_pkg::REG_SOUTH, {47'd0, sp});
    write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
  endtask

  task automatic add_point(input longint s, input longint l);
    geo_point_t pt;
    pt.sin_lat = s[31:0];
    pt.lon_rad = l[31:0];
    pending_points.push_back(pt);
  endtask

  task automatic drain();
    wait (pending_points.size() == 0 && !in_ch.valid && expected_points.size() == 0);
    repeat (LATENCY + 12) @(negedge clk);
  endtask

  task automatic add_phase_points();
    longint s, l;
    add_point(0, 0);
    add_point(SIN_ONE, LON_MAX);
    add_point(-SIN_ONE, -LON_MAX);
    add_point(1, -1);
    add_point(-1, LON_MAX);
    add_point(SIN_ONE / 2, -LON_MAX / 3);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      s = longint'($urandom_range(0, 32'(2 * SIN_ONE))) - SIN_ONE;
      l = longint'($urandom_range(0, 32'(2 * LON_MAX))) - LON_MAX;
      add_point(s, l);
    end
  endtask

  // stimulus and phase sequencing
  initial begin
    logic [47:0] r0;
    logic [31:0] n, e2;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sin_lat = '0;
    in_ch.lon_rad = '0;
    out_ch.ready = 1'b0;
    hold_send = 1'b1;
    r0sq_sh = alb_pkg::R0SQ_RST;
    cone_sh = alb_pkg::CONE_RST;
    ecc_sh = '0;
    south_sh = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: ;
        1: set_projection(48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        2: set_projection(48'd0, 32'h8000_0000, 32'd0, 1'b0);
        3: set_projection(48'({$urandom, $urandom}) & 48'h000F_FFFF_FFFF, 32'd0,
                          $urandom, 1'b1);
        4: set_projection(48'h0002_0000_0000, 32'd1000, 32'd28_000_000, 1'b0);
        5: set_projection(48'h0000_0000_0001, 32'hFFFF_FC18, 32'hFFFF_FFFF, 1'b1);
        default: begin
          r0 = 48'({$urandom, $urandom} >> $urandom_range(12, 40));
          n  = $urandom;
          e2 = $urandom_range(0, 1) ? $urandom : 32'd0;
          set_projection(r0, n, e2, 1'($urandom_range(0, 1)));
        end
      endcase
      add_phase_points();
      hold_send = 1'b0;
      wait (pending_points.size() == 0);
      hold_send = 1'b1;
      drain();
    end
    $display("covered %0d transactions over %0d register settings, %0d clamped radicands",
             n_recv, N_PHASES, n_clamped);
    $display("with random source gaps, sink stalls and full drains between settings");
    if (errors == 0 && expected_points.size() == 0)
      $display("albers_forward_projection_top test passed");
    else
      $display("albers_forward_projection_top test failed");
    $finish;
  end

  // driver: bursts with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      in_taken = 1'b0;
      if (gap_cnt > 0) begin
        gap_cnt--;
        in_ch.valid <= 1'b0;
      end else if (!hold_send && pending_points.size() > 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.sin_lat <= pending_points[0].sin_lat;
        in_ch.lon_rad <= pending_points[0].lon_rad;
        void'(pending_points.pop_front());
        if (burst_cnt > 0) begin
          burst_cnt--;
        end else begin
          burst_cnt = $urandom_range(0, 40);
          gap_cnt   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with calm stretches
  always @(negedge clk) begin
    if (rst_n) begin
      if (calm_cnt > 0) begin
        calm_cnt--;
        out_ch.ready <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        case ($urandom_range(0, 15))
          0:       calm_cnt  = $urandom_range(50, 300);
          1, 2, 3: stall_cnt = $urandom_range(1, 20);
          default: ;
        endcase
      end
    end
  end

  // input side: predict on each accepted transaction
  always @(posedge clk) begin
    geo_point_t pt;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      pt.sin_lat = in_ch.sin_lat;
      pt.lon_rad = in_ch.lon_rad;
      expected_points.push_back(project_point(pt));
      in_taken = 1'b1;
      n_sent++;
    end
  end

  // output side: compare with the oldest prediction
  always @(posedge clk) begin
    plane_point_t exp_pt;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_recv++;
      if (expected_points.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (!exp_pt.ok) n_clamped++;
        if (out_ch.x_out !== exp_pt.x) begin
          $error("x_out: expected %0d, got %0d", exp_pt.x, out_ch.x_out);
          errors++;
        end
        if (out_ch.y_out !== exp_pt.y) begin
          $error("y_out: expected %0d, got %0d", exp_pt.y, out_ch.y_out);
          errors++;
        end
        if (out_ch.valid_res !== exp_pt.ok) begin
          $error("valid_res: expected %0d, got %0d", exp_pt.ok, out_ch.valid_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("albers_forward_projection_top test failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    n_sent = 0;
    n_recv = 0;
    n_clamped = 0;
    idle_cycles = 0;
    in_taken = 1'b0;
    gap_cnt = 0;
    burst_cnt = 0;
    stall_cnt = 0;
    calm_cnt = 0;
  end

endmodule
